@@ src/bencode_stream_tokenizer_defines.svh @@
// ----------------------------------------------------------------------------
// Bencode stream tokenizer assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef BENCODE_STREAM_TOKENIZER_DEFINES_SVH
`define BENCODE_STREAM_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bst_pkg.sv @@
// ----------------------------------------------------------------------------
// Bencode stream tokenizer package
// Widths, character codes, error codes, clamp constants, phase and token kind types.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int MAX_DEPTH  = 32;
  localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);
  localparam int SIDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int NEST_W     = 6;
  localparam int VALUE_W    = 33;
  localparam int ACC_W      = 32;
  localparam int KIND_W     = 3;
  localparam int OUT_DATA_W = ((VALUE_W + NEST_W + 7) / 8) * 8;
  localparam int PAD_W      = OUT_DATA_W - VALUE_W - NEST_W;

  localparam logic [ACC_W-1:0] CLAMP_LIMIT = 32'd214748364;
  localparam logic [ACC_W-1:0] CLAMP_VALUE = 32'd2147483647;

  localparam logic [7:0] CH_I     = 8'h69;  // 'i'
  localparam logic [7:0] CH_E     = 8'h65;  // 'e'
  localparam logic [7:0] CH_COLON = 8'h3a;  // ':'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_L     = 8'h6c;  // 'l'
  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_9     = 8'h39;  // '9'

  localparam logic [1:0] ERR_BAD_BYTE  = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_NEG_LEN   = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_INT_SIGN,
    PH_INT_DIGITS,
    PH_STR_LEN,
    PH_STR_BODY
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    TK_INT   = 3'd0,
    TK_HDR   = 3'd1,
    TK_SBYTE = 3'd2,
    TK_LIST  = 3'd3,
    TK_DICT  = 3'd4,
    TK_CLOSE = 3'd5,
    TK_ERR   = 3'd6
  } kind_t;

endpackage

@@ src/bencode_stream_tokenizer.sv @@
// ----------------------------------------------------------------------------
// Bencode stream tokenizer
// Turns a bencoded byte stream into integer, string and container tokens.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the token output is not stalled, and gives at
// most one token per byte. A byte passes an input register, then one decode
// step against the parser state loads the result register. Integers come out
// at their closing 'e', string headers at the ':', then one token per string
// byte; opens and closes carry the nesting depth. Numbers clamp to
// +/-2147483647 once past 214748364. Any error gives one error token and the
// block then swallows input silently until reset. No clearing pass after
// reset; the container stack holds its kinds without reset.
module bencode_stream_tokenizer import bst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte[7:0]
  input  logic                  in_tlast,   // last_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // token_value[32:0], nest_depth[38:33], pad
  output logic [KIND_W-1:0]     out_tuser   // token_kind[2:0]
);

  // input stage
  logic                      s0_vld_r;
  logic [7:0]                s0_byte_r;
  logic                      s0_last_r;

  // parser state
  phase_t                    phase_r, phase_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic                      neg_r, neg_nxt;
  logic                      clamp_r, clamp_nxt;
  logic [ACC_W-1:0]          left_r, left_nxt;
  logic [DEPTH_W-1:0]        depth_r, depth_nxt;
  logic                      err_r;
  logic [MAX_DEPTH-1:0]      stack_r;

  // result stage
  logic                      out_vld_r;
  kind_t                     out_kind_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [NEST_W-1:0]         out_depth_r;

  logic                      adv, proc;
  logic                      is_digit;
  logic [3:0]                dig_val;
  logic [ACC_W-1:0]          acc_base, acc_dig;
  logic                      clamp_base, clamp_dig;
  logic                      tok_have, tok_err, push;
  kind_t                     tok_kind;
  logic signed [VALUE_W-1:0] tok_value;
  logic [VALUE_W-1:0]        acc_ext;
  logic [SIDX_W-1:0]         push_idx, pop_idx;

  assign adv       = !out_vld_r || out_tready;
  assign proc      = s0_vld_r && adv;
  assign in_tready = !s0_vld_r || adv;

  assign is_digit = (s0_byte_r >= CH_0) && (s0_byte_r <= CH_9);
  assign dig_val  = 4'(s0_byte_r - CH_0);
  assign acc_ext  = {1'b0, acc_r};
  assign push_idx = SIDX_W'(depth_r);
  assign pop_idx  = SIDX_W'(depth_r - DEPTH_W'(1));

  // a digit in idle starts a fresh number
  assign acc_base   = (phase_r == PH_IDLE) ? '0 : acc_r;
  assign clamp_base = (phase_r == PH_IDLE) ? 1'b0 : clamp_r;

  always_comb begin
    acc_dig   = acc_base;
    clamp_dig = clamp_base;
    if (!clamp_base) begin
      if (acc_base > CLAMP_LIMIT) begin
        clamp_dig = 1'b1;
        acc_dig   = CLAMP_VALUE;
      end else begin
        acc_dig = (acc_base << 3) + (acc_base << 1) + ACC_W'(dig_val);
      end
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        if (s0_byte_r == CH_I) begin
          phase_nxt = PH_INT_SIGN;
        end else if (is_digit) begin
          phase_nxt = PH_STR_LEN;
        end
      end
      PH_INT_SIGN, PH_INT_DIGITS: begin
        if ((s0_byte_r == CH_MINUS && phase_r == PH_INT_SIGN) || is_digit) begin
          phase_nxt = PH_INT_DIGITS;
        end else if (s0_byte_r == CH_E) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_STR_LEN: begin
        if (!is_digit && s0_byte_r == CH_COLON) begin
          phase_nxt = (acc_r == '0) ? PH_IDLE : PH_STR_BODY;
        end
      end
      PH_STR_BODY: begin
        if (left_r <= ACC_W'(1)) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // token and datapath
  always_comb begin
    tok_have  = 1'b0;
    tok_err   = 1'b0;
    tok_kind  = TK_INT;
    tok_value = '0;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    clamp_nxt = clamp_r;
    left_nxt  = left_r;
    depth_nxt = depth_r;
    push      = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (s0_byte_r == CH_I) begin
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
          clamp_nxt = 1'b0;
        end else if (is_digit) begin
          acc_nxt   = acc_dig;
          clamp_nxt = clamp_dig;
          neg_nxt   = 1'b0;
        end else if (s0_byte_r inside {CH_L, CH_D}) begin
          if (depth_r >= DEPTH_W'(MAX_DEPTH)) begin
            tok_err   = 1'b1;
            tok_value = VALUE_W'(ERR_OVERFLOW);
          end else begin
            push      = 1'b1;
            depth_nxt = depth_r + DEPTH_W'(1);
            tok_have  = 1'b1;
            tok_kind  = (s0_byte_r == CH_D) ? TK_DICT : TK_LIST;
          end
        end else if (s0_byte_r == CH_E) begin
          // close at depth zero is dropped
          if (depth_r != '0) begin
            depth_nxt = depth_r - DEPTH_W'(1);
            tok_have  = 1'b1;
            tok_kind  = TK_CLOSE;
            tok_value = VALUE_W'(stack_r[pop_idx]);
          end
        end else if (s0_byte_r == CH_MINUS) begin
          tok_err   = 1'b1;
          tok_value = VALUE_W'(ERR_NEG_LEN);
        end else begin
          tok_err   = 1'b1;
          tok_value = VALUE_W'(ERR_BAD_BYTE);
        end
      end
      PH_INT_SIGN, PH_INT_DIGITS: begin
        if (s0_byte_r == CH_MINUS && phase_r == PH_INT_SIGN) begin
          neg_nxt = 1'b1;
        end else if (is_digit) begin
          acc_nxt   = acc_dig;
          clamp_nxt = clamp_dig;
        end else if (s0_byte_r == CH_E) begin
          tok_have  = 1'b1;
          tok_kind  = TK_INT;
          tok_value = neg_r ? -acc_ext : acc_ext;
        end else begin
          tok_err   = 1'b1;
          tok_value = VALUE_W'(ERR_BAD_BYTE);
        end
      end
      PH_STR_LEN: begin
        if (is_digit) begin
          acc_nxt   = acc_dig;
          clamp_nxt = clamp_dig;
        end else if (s0_byte_r == CH_COLON) begin
          tok_have  = 1'b1;
          tok_kind  = TK_HDR;
          tok_value = acc_ext;
          left_nxt  = acc_r;
        end else begin
          tok_err   = 1'b1;
          tok_value = VALUE_W'(ERR_BAD_BYTE);
        end
      end
      PH_STR_BODY: begin
        tok_have  = 1'b1;
        tok_kind  = TK_SBYTE;
        tok_value = VALUE_W'(s0_byte_r);
        if (left_r != '0) begin
          left_nxt = left_r - ACC_W'(1);
        end
      end
      default: begin
        tok_err   = 1'b1;
        tok_value = VALUE_W'(ERR_BAD_BYTE);
      end
    endcase

    // buffer ends with a value or a container still open
    if (!tok_err && s0_last_r && (phase_nxt != PH_IDLE || depth_nxt != '0)) begin
      tok_err   = 1'b1;
      tok_value = VALUE_W'(ERR_TRUNCATED);
    end
    if (tok_err) begin
      tok_have = 1'b1;
      tok_kind = TK_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_tready) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_byte_r <= in_tdata;
      s0_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      clamp_r <= 1'b0;
      left_r  <= '0;
      depth_r <= '0;
      err_r   <= 1'b0;
    end else if (proc && !err_r) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      clamp_r <= clamp_nxt;
      left_r  <= left_nxt;
      depth_r <= depth_nxt;
      err_r   <= tok_err;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && !err_r && push) begin
      stack_r[push_idx] <= (s0_byte_r == CH_D);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= proc && !err_r && tok_have;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && !err_r && tok_have) begin
      out_kind_r  <= tok_kind;
      out_value_r <= tok_value;
      out_depth_r <= NEST_W'(depth_nxt);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_depth_r, out_value_r};
  assign out_tuser  = out_kind_r;

endmodule

@@ src/bst_checker.sv @@
// ----------------------------------------------------------------------------
// Bencode stream tokenizer port checker
// Watches the token channel of the tokenizer; bound into the tokenizer module.
// ----------------------------------------------------------------------------
`include "bencode_stream_tokenizer_defines.svh"

module bst_checker import bst_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,  // token_value[32:0], nest_depth[38:33], pad
  input logic [KIND_W-1:0]     out_tuser   // token_kind[2:0]
);

  `BST_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled token changed")

  `BST_ASSERT_NEXT(a_err_sticky, out_tvalid && out_tready && out_tuser == TK_ERR, !out_tvalid, "token after error")

  `BST_ASSERT_NOW(a_sbyte, out_tvalid && out_tuser == TK_SBYTE, out_tdata[VALUE_W-1:8] == '0, "string byte out of range")

  `BST_ASSERT_NOW(a_open, out_tvalid && (out_tuser == TK_LIST || out_tuser == TK_DICT), out_tdata[VALUE_W-1:0] == '0 && out_tdata[VALUE_W+NEST_W-1:VALUE_W] != '0, "bad open token")

endmodule

bind bencode_stream_tokenizer bst_checker u_bst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Bencode stream tokenizer testbench
// Feeds byte streams with random gaps and stalls on both sides. Each accepted
// byte is run through a local tokenizer model and every token coming out is
// compared field by field. A short table opens the run, well-formed buffers
// with random content follow, and one error sequence closes it.
// ----------------------------------------------------------------------------
module testbench import bst_pkg::*;;

  localparam int RANDOM_ITEMS = 1350;

  typedef struct packed {
    kind_t               kind;
    logic [VALUE_W-1:0]  value;
    logic [NEST_W-1:0]   depth;
  } token_t;

  typedef struct {
    logic [7:0] data;
    bit         last;
    bit         pinned;   // expected token typed in below, not predicted
    token_t     tok;
  } byte_item_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;

  byte_item_t byte_plan[$];
  token_t     expected_tokens[$];
  int         sent_count;
  int         recv_count;
  int         mismatches;

  // tokenizer model state
  phase_t      tz_phase;
  logic [31:0] tz_acc;
  bit          tz_neg;
  bit          tz_clamped;
  logic [31:0] tz_left;
  bit          tz_stack [MAX_DEPTH];
  int unsigned tz_depth;
  bit          tz_stuck;

  bencode_stream_tokenizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at token %0d: %s", recv_count, msg);
    mismatches++;
  endtask

  // every fourth stretch of 64 transactions runs without idling
  function automatic int pick_gap(input int count);
    if ((count / 64) % 4 == 2) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic void clear_number();
    tz_acc     = '0;
    tz_neg     = 1'b0;
    tz_clamped = 1'b0;
  endfunction

  function automatic void push_digit(input logic [7:0] b);
    if (tz_clamped) return;
    if (tz_acc > CLAMP_LIMIT) begin
      tz_clamped = 1'b1;
      tz_acc     = CLAMP_VALUE;
      return;
    end
    tz_acc = tz_acc * 10 + 32'(b - CH_0);
  endfunction

  // Advances the model by one byte; returns 1 when a token comes out.
  function automatic bit tokenize(input logic [7:0] b, input bit last, output token_t tok);
    bit                 have;
    bit                 err;
    bit                 is_digit;
    logic [VALUE_W-1:0] val;
    kind_t              k;
    have     = 1'b0;
    err      = 1'b0;
    val      = '0;
    k        = TK_INT;
    tok      = '0;
    is_digit = (b >= CH_0) && (b <= CH_9);
    if (tz_stuck) return 1'b0;
    case (tz_phase)
      PH_IDLE: begin
        if (b == CH_I) begin
          clear_number();
          tz_phase = PH_INT_SIGN;
        end else if (is_digit) begin
          clear_number();
          push_digit(b);
          tz_phase = PH_STR_LEN;
        end else if (b == CH_L || b == CH_D) begin
          if (tz_depth >= MAX_DEPTH) begin
            err = 1'b1;
            val = VALUE_W'(ERR_OVERFLOW);
          end else begin
            tz_stack[tz_depth] = (b == CH_D);
            tz_depth++;
            have = 1'b1;
            if (b == CH_D) k = TK_DICT;
            else k = TK_LIST;
          end
        end else if (b == CH_E) begin
          // a close at depth zero is dropped silently
          if (tz_depth > 0) begin
            tz_depth--;
            have = 1'b1;
            k    = TK_CLOSE;
            val  = VALUE_W'(tz_stack[tz_depth]);
          end
        end else if (b == CH_MINUS) begin
          err = 1'b1;
          val = VALUE_W'(ERR_NEG_LEN);
        end else begin
          err = 1'b1;
          val = VALUE_W'(ERR_BAD_BYTE);
        end
      end
      PH_INT_SIGN, PH_INT_DIGITS: begin
        if (b == CH_MINUS && tz_phase == PH_INT_SIGN) begin
          tz_neg   = 1'b1;
          tz_phase = PH_INT_DIGITS;
        end else if (is_digit) begin
          push_digit(b);
          tz_phase = PH_INT_DIGITS;
        end else if (b == CH_E) begin
          have     = 1'b1;
          k        = TK_INT;
          val      = tz_neg ? -{1'b0, tz_acc} : {1'b0, tz_acc};
          tz_phase = PH_IDLE;
        end else begin
          err = 1'b1;
          val = VALUE_W'(ERR_BAD_BYTE);
        end
      end
      PH_STR_LEN: begin
        if (is_digit) begin
          push_digit(b);
        end else if (b == CH_COLON) begin
          have    = 1'b1;
          k       = TK_HDR;
          val     = {1'b0, tz_acc};
          tz_left = tz_acc;
          if (tz_left == 0) tz_phase = PH_IDLE;
          else tz_phase = PH_STR_BODY;
        end else begin
          err = 1'b1;
          val = VALUE_W'(ERR_BAD_BYTE);
        end
      end
      default: begin
        have = 1'b1;
        k    = TK_SBYTE;
        val  = {25'd0, b};
        if (tz_left > 0) tz_left--;
        if (tz_left == 0) tz_phase = PH_IDLE;
      end
    endcase
    // end of buffer inside a value or an open container
    if (!err && last && (tz_phase != PH_IDLE || tz_depth > 0)) begin
      err = 1'b1;
      val = VALUE_W'(ERR_TRUNCATED);
    end
    if (err) begin
      tz_stuck = 1'b1;
      have     = 1'b1;
      k        = TK_ERR;
    end
    tok.kind  = k;
    tok.value = val;
    tok.depth = NEST_W'(tz_depth);
    return have;
  endfunction

  task automatic plan_byte(input logic [7:0] b, input bit last);
    byte_item_t it;
    it.data   = b;
    it.last   = last;
    it.pinned = 1'b0;
    it.tok    = '0;
    byte_plan.push_back(it);
  endtask

  task automatic plan_token(input logic [7:0] b, input bit last, input kind_t k,
                            input logic [VALUE_W-1:0] v, input logic [NEST_W-1:0] d);
    byte_item_t it;
    it.data      = b;
    it.last      = last;
    it.pinned    = 1'b1;
    it.tok.kind  = k;
    it.tok.value = v;
    it.tok.depth = d;
    byte_plan.push_back(it);
  endtask

  task automatic plan_text(input string s);
    for (int i = 0; i < s.len(); i++) plan_byte(s[i], 1'b0);
  endtask

  task automatic end_buffer();
    byte_item_t it;
    it = byte_plan.pop_back();
    it.last = 1'b1;
    byte_plan.push_back(it);
  endtask

  task automatic plan_int();
    int r;
    plan_byte(CH_I, 1'b0);
    if ($urandom_range(0, 2) == 0) plan_byte(CH_MINUS, 1'b0);
    r = $urandom_range(0, 9);
    if (r < 6) begin
      repeat ($urandom_range(0, 3)) plan_byte(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
    end else if (r < 8) begin
      repeat ($urandom_range(8, 12)) plan_byte(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
    end else begin
      // values around the clamp point
      case ($urandom_range(0, 5))
        0: plan_text("214748364");
        1: plan_text("2147483647");
        2: plan_text("2147483648");
        3: plan_text("2147483649");
        4: plan_text("2147483650");
        default: plan_text("00021474836479");
      endcase
    end
    plan_byte(CH_E, 1'b0);
  endtask

  task automatic plan_string();
    int len;
    if ($urandom_range(0, 7) == 0) len = $urandom_range(6, 20);
    else len = $urandom_range(0, 5);
    if ($urandom_range(0, 7) == 0) plan_byte(CH_0, 1'b0);
    plan_text($sformatf("%0d", len));
    plan_byte(CH_COLON, 1'b0);
    repeat (len) plan_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_item(input byte_item_t it);
    int     gap;
    token_t tok;
    bit     have;
    gap = pick_gap(sent_count);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.data;
    in_tlast  <= it.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    have = tokenize(it.data, it.last, tok);
    if (it.pinned) expected_tokens.push_back(it.tok);
    else if (have) expected_tokens.push_back(tok);
    sent_count++;
  endtask

  initial begin : token_monitor
    token_t want;
    int     stall;
    stall = 0;
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_tokens.size() == 0) begin
          flag_mismatch($sformatf("unexpected token kind %0d value %h", out_tuser,
                                  out_tdata[VALUE_W-1:0]));
        end else begin
          want = expected_tokens.pop_front();
          if (out_tuser !== want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", out_tuser, want.kind));
          if (out_tdata[VALUE_W-1:0] !== want.value)
            flag_mismatch($sformatf("value %h, want %h", out_tdata[VALUE_W-1:0], want.value));
          if (out_tdata[VALUE_W +: NEST_W] !== want.depth)
            flag_mismatch($sformatf("depth %0d, want %0d", out_tdata[VALUE_W +: NEST_W],
                                    want.depth));
        end
        recv_count++;
        stall = pick_gap(recv_count);
        if (stall > 0) out_tready <= 1'b0;
      end else if (!out_tready) begin
        if (stall > 0) stall--;
        if (stall == 0) out_tready <= 1'b1;
      end
    end
  end

  initial begin : stream_driver
    int         table_rows;
    int         pick;
    int         nest_cap;
    int         deep;
    int         opens;
    int         sub;
    int         wait_cycles;
    bit         first;
    bit         key;
    bit         dict_open;
    bit         bad_last;
    logic [1:0] err_pick;
    logic [7:0] bad;
    bit         lvl_dict[$];
    int         lvl_left[$];

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    sent_count  = 0;
    recv_count  = 0;
    mismatches  = 0;
    tz_phase    = PH_IDLE;
    clear_number();
    tz_left     = '0;
    tz_depth    = 0;
    tz_stuck    = 1'b0;

    // directed rows
    plan_byte(CH_I, 1'b0);
    plan_token(CH_E, 1'b1, TK_INT, '0, '0);          // empty integer, clean end
    plan_byte(CH_E, 1'b0);                           // stray close
    plan_byte(CH_I, 1'b0);
    plan_byte(CH_MINUS, 1'b0);
    plan_token(CH_E, 1'b0, TK_INT, '0, '0);          // "i-e"
    plan_byte(CH_I, 1'b0);
    plan_byte(CH_MINUS, 1'b0);
    plan_byte(CH_0, 1'b0);
    plan_byte(CH_0, 1'b0);
    plan_byte(CH_0 + 8'd7, 1'b0);
    plan_byte(CH_E, 1'b0);                           // leading zeros
    plan_byte(CH_0, 1'b0);
    plan_token(CH_COLON, 1'b0, TK_HDR, '0, '0);      // empty string
    plan_token(CH_L, 1'b0, TK_LIST, '0, 6'd1);
    plan_token(CH_D, 1'b0, TK_DICT, '0, 6'd2);
    plan_byte(CH_0 + 8'd2, 1'b0);
    plan_token(CH_COLON, 1'b0, TK_HDR, 33'd2, 6'd2);
    plan_token(8'hff, 1'b0, TK_SBYTE, 33'd255, 6'd2);
    plan_token(8'h00, 1'b0, TK_SBYTE, '0, 6'd2);
    plan_token(CH_E, 1'b0, TK_CLOSE, 33'd1, 6'd1);
    plan_token(CH_E, 1'b1, TK_CLOSE, '0, '0);
    table_rows = byte_plan.size();

    // well-formed buffers with random content; every buffer returns to depth 0
    while (byte_plan.size() < table_rows + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        if ($urandom_range(0, 3) == 0) deep = MAX_DEPTH;
        else deep = $urandom_range(4, MAX_DEPTH - 1);
        repeat (deep) plan_byte($urandom_range(0, 1) ? CH_D : CH_L, 1'b0);
        plan_int();
        repeat (deep) plan_byte(CH_E, 1'b0);
        end_buffer();
      end else if (pick == 1) begin
        plan_byte(CH_E, 1'($urandom_range(0, 1)));
      end else begin
        nest_cap = $urandom_range(0, 3);
        first    = 1'b1;
        while (first || lvl_dict.size() > 0) begin
          if (!first && lvl_left[lvl_left.size()-1] == 0) begin
            plan_byte(CH_E, 1'b0);
            void'(lvl_dict.pop_back());
            void'(lvl_left.pop_back());
          end else begin
            key = 1'b0;
            if (!first) begin
              lvl_left[lvl_left.size()-1] = lvl_left[lvl_left.size()-1] - 1;
              // dict entries alternate key, value
              key = lvl_dict[lvl_dict.size()-1] && (lvl_left[lvl_left.size()-1] % 2 == 1);
            end
            first = 1'b0;
            pick  = $urandom_range(0, 9);
            if (key) begin
              plan_string();
            end else if (lvl_dict.size() < nest_cap && pick < 4) begin
              dict_open = 1'($urandom_range(0, 1));
              plan_byte(dict_open ? CH_D : CH_L, 1'b0);
              lvl_dict.push_back(dict_open);
              lvl_left.push_back(dict_open ? 2 * $urandom_range(0, 3) : $urandom_range(0, 3));
            end else if (pick < 7) begin
              plan_int();
            end else begin
              plan_string();
            end
          end
        end
        // some buffers carry several top-level values
        if ($urandom_range(0, 3) != 0) end_buffer();
      end
    end

    // closing error sequence; the error is sticky, so it comes once and last
    opens    = $urandom_range(0, 2);
    bad_last = 1'($urandom_range(0, 1));
    repeat (opens) plan_byte($urandom_range(0, 1) ? CH_D : CH_L, 1'b0);
    err_pick = 2'($urandom_range(0, 3));
    case (err_pick)
      ERR_BAD_BYTE: begin
        sub = $urandom_range(0, 2);
        if (sub == 0) begin
          do bad = 8'($urandom_range(0, 255));
          while (bad == CH_I || bad == CH_L || bad == CH_D || bad == CH_E ||
                 bad == CH_MINUS || (bad >= CH_0 && bad <= CH_9));
          plan_byte(bad, bad_last);
        end else if (sub == 1) begin
          plan_byte(CH_I, 1'b0);
          plan_byte(CH_MINUS, 1'b0);
          plan_byte(CH_MINUS, bad_last);             // second sign
        end else begin
          plan_byte(CH_0 + 8'd3, 1'b0);
          plan_byte(CH_E, bad_last);                 // non-digit in a length
        end
      end
      ERR_TRUNCATED: begin
        sub = $urandom_range(0, (opens > 0) ? 3 : 2);
        if (sub == 0) begin
          plan_text("i12");
        end else if (sub == 1) begin
          // huge header, buffer ends inside the body
          case ($urandom_range(0, 2))
            0: plan_text("2147483649");
            1: plan_text("4294967295");
            default: plan_text("99999999999");
          endcase
          plan_byte(CH_COLON, 1'b0);
          repeat (3) plan_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (sub == 2) begin
          plan_byte(CH_L, 1'b0);
        end else begin
          plan_text("i7e");                          // complete value, container still open
        end
        end_buffer();
      end
      ERR_NEG_LEN: begin
        plan_byte(CH_MINUS, bad_last);
      end
      default: begin
        repeat (MAX_DEPTH - opens) plan_byte(CH_L, 1'b0);
        plan_byte(CH_D, bad_last);
      end
    endcase
    // swallowed after the error
    repeat (12) plan_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (byte_plan[i]) send_item(byte_plan[i]);
    in_tvalid <= 1'b0;

    for (wait_cycles = 0; wait_cycles < 2000 && expected_tokens.size() != 0; wait_cycles++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_tokens.size() != 0)
      flag_mismatch($sformatf("%0d expected tokens never arrived", expected_tokens.size()));

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
